// File: rtl/multi_channel_interval_timer_macros.svh
// Assertion helpers shared by the timer RTL. Each expects clk and rst_n in scope.
`ifndef MULTI_CHANNEL_INTERVAL_TIMER_MACROS_SVH
`define MULTI_CHANNEL_INTERVAL_TIMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCIT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCIT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mcit_pkg.sv
package mcit_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Command queue between front and back; depth is a power of two.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  channel;
    logic [39:0] interval_ns;
    logic        repeat_req;
    logic [62:0] now_ns;
  } in_t;

  typedef struct packed {
    logic [2:0] fired_channel;
    logic       last;
  } out_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_START,
    CMD_STOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [IDX_W-1:0]  chan;
    logic [39:0]       interval_ns;
    logic              repeat_req;
    logic [62:0]       now_ns;
  } cmd_t;

  typedef struct packed {
    logic push;
    out_t beat;
  } res_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

endpackage

// File: rtl/mcit_front.sv
module mcit_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  mcit_pkg::in_t   in_data,
  output logic            cmd_vld,
  output mcit_pkg::cmd_t  cmd,
  input  logic            cmd_pop
);

  mcit_pkg::cmd_t                  q_r [mcit_pkg::QDEPTH];
  logic [mcit_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [mcit_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [mcit_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                            accept;
  logic                            keep;
  logic                            push;
  mcit_pkg::cmd_t                  dec;

  assign in_stall = (count_r == mcit_pkg::QCNT_W'(mcit_pkg::QDEPTH));
  assign accept   = in_valid && !in_stall;

  // Classify the beat; drop unknown codes and out-of-range channels.
  always_comb begin
    dec.chan        = mcit_pkg::IDX_W'(in_data.channel);
    dec.interval_ns = in_data.interval_ns;
    dec.repeat_req  = in_data.repeat_req;
    dec.now_ns      = in_data.now_ns;
    dec.kind        = mcit_pkg::CMD_TICK;
    keep            = 1'b0;
    unique case (in_data.operation)
      mcit_pkg::OP_TICK: begin
        keep = 1'b1;
      end
      mcit_pkg::OP_START: begin
        dec.kind = mcit_pkg::CMD_START;
        keep     = (32'(in_data.channel) < mcit_pkg::NUM_CHANNELS);
      end
      mcit_pkg::OP_STOP: begin
        dec.kind = mcit_pkg::CMD_STOP;
        keep     = (32'(in_data.channel) < mcit_pkg::NUM_CHANNELS);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push    = accept && keep;
  assign cmd_vld = (count_r != '0);
  assign cmd     = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + mcit_pkg::QCNT_W'(push) - mcit_pkg::QCNT_W'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// File: rtl/mcit_back.sv
`include "multi_channel_interval_timer_macros.svh"

module mcit_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_vld,
  input  mcit_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  input  logic                res_free,
  output mcit_pkg::res_ctl_t  res
);

  localparam logic [mcit_pkg::IDX_W-1:0] LAST_IDX = mcit_pkg::IDX_W'(mcit_pkg::NUM_CHANNELS - 1);

  logic [mcit_pkg::NUM_CHANNELS-1:0] armed_r;
  logic [63:0]                       deadline_r [mcit_pkg::NUM_CHANNELS];
  logic [39:0]                       period_r   [mcit_pkg::NUM_CHANNELS];
  logic [mcit_pkg::NUM_CHANNELS-1:0] periodic_r;

  mcit_pkg::state_t        state_r, state_nxt;
  logic [mcit_pkg::IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [62:0]             now_r, now_nxt;
  logic                    hold_vld_r, hold_vld_nxt;
  logic [mcit_pkg::IDX_W-1:0] hold_ch_r, hold_ch_nxt;

  logic [mcit_pkg::IDX_W-1:0] wr_idx;
  logic                    arm_set, arm_clr, dl_we, cfg_we;
  logic [63:0]             dl_wdata;
  logic [63:0]             cur_dl;
  logic                    due;
  logic                    step_en;

  assign cur_dl  = deadline_r[scan_idx_r];
  assign due     = armed_r[scan_idx_r] && (cur_dl <= {1'b0, now_r});
  assign step_en = (state_r == mcit_pkg::ST_SCAN) && res_free;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mcit_pkg::ST_IDLE: begin
        if (cmd_vld && cmd.kind == mcit_pkg::CMD_TICK) state_nxt = mcit_pkg::ST_SCAN;
      end
      mcit_pkg::ST_SCAN: begin
        if (res_free && scan_idx_r == LAST_IDX) state_nxt = mcit_pkg::ST_FLUSH;
      end
      mcit_pkg::ST_FLUSH: begin
        if (!hold_vld_r || res_free) state_nxt = mcit_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mcit_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath controls.
  always_comb begin
    cmd_pop      = 1'b0;
    arm_set      = 1'b0;
    arm_clr      = 1'b0;
    dl_we        = 1'b0;
    cfg_we       = 1'b0;
    wr_idx       = cmd.chan;
    dl_wdata     = 64'(cmd.now_ns) + 64'(cmd.interval_ns);
    res.push     = 1'b0;
    res.beat.fired_channel = 3'(hold_ch_r);
    res.beat.last          = 1'b0;
    scan_idx_nxt = scan_idx_r;
    now_nxt      = now_r;
    hold_vld_nxt = hold_vld_r;
    hold_ch_nxt  = hold_ch_r;
    unique case (state_r)
      mcit_pkg::ST_IDLE: begin
        if (cmd_vld) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            mcit_pkg::CMD_START: begin
              arm_set = 1'b1;
              dl_we   = 1'b1;
              cfg_we  = 1'b1;
            end
            mcit_pkg::CMD_STOP: begin
              arm_clr = 1'b1;
            end
            default: begin
              now_nxt      = cmd.now_ns;
              scan_idx_nxt = '0;
              hold_vld_nxt = 1'b0;
            end
          endcase
        end
      end
      mcit_pkg::ST_SCAN: begin
        wr_idx   = scan_idx_r;
        dl_wdata = cur_dl + 64'(period_r[scan_idx_r]);
        if (step_en) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
          if (due) begin
            // Emit the previous firing; this one is now the candidate for last.
            res.push     = hold_vld_r;
            hold_vld_nxt = 1'b1;
            hold_ch_nxt  = scan_idx_r;
            dl_we        = periodic_r[scan_idx_r];
            arm_clr      = !periodic_r[scan_idx_r];
          end
        end
      end
      mcit_pkg::ST_FLUSH: begin
        if (hold_vld_r && res_free) begin
          res.push      = 1'b1;
          res.beat.last = 1'b1;
          hold_vld_nxt  = 1'b0;
        end
      end
      default: begin
        hold_vld_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mcit_pkg::ST_IDLE;
      hold_vld_r <= 1'b0;
      armed_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      hold_vld_r <= hold_vld_nxt;
      if (arm_set) armed_r[wr_idx] <= 1'b1;
      if (arm_clr) armed_r[wr_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    now_r      <= now_nxt;
    hold_ch_r  <= hold_ch_nxt;
    if (dl_we) deadline_r[wr_idx] <= dl_wdata;
    if (cfg_we) begin
      period_r[wr_idx]   <= cmd.interval_ns;
      periodic_r[wr_idx] <= cmd.repeat_req;
    end
  end

  `MCIT_ASSERT_IMP(a_push_only_scan_flush, res.push, (state_r == mcit_pkg::ST_SCAN) || (state_r == mcit_pkg::ST_FLUSH), "result pushed outside a tick scan")
  `MCIT_ASSERT_IMP(a_push_when_free, res.push, res_free, "result pushed into a full output register")
  `MCIT_ASSERT_IMP(a_flush_marks_last, res.push && state_r == mcit_pkg::ST_FLUSH, res.beat.last, "final firing of a tick lacks last")
  `MCIT_ASSERT_IMP(a_idle_no_hold, state_r == mcit_pkg::ST_IDLE, !hold_vld_r, "held firing left over after a tick")
  `MCIT_ASSERT_NXT(a_fire_disarms_one_shot, step_en && due && !periodic_r[scan_idx_r], !armed_r[$past(scan_idx_r)], "one-shot channel still armed after firing")

endmodule

// File: rtl/multi_channel_interval_timer.sv
// Multi-channel interval timer. Holds mcit_pkg::NUM_CHANNELS channels, each with an armed
// flag, a 64-bit nanosecond deadline, a 40-bit period and a periodic flag. A start beat
// arms a channel with deadline = now_ns + interval_ns; a stop beat disarms it; a tick beat
// scans all channels in index order and emits one out beat per armed channel whose
// deadline is at or before now_ns, with last set on the final firing of that tick (a tick
// with nothing due emits nothing). Periodic channels advance by one period per tick,
// one-shot channels disarm. Operation code 3 and out-of-range channels are dropped.
// Flow: the front part classifies beats into a two-entry command queue, so in_stall
// rises only when that queue is full. The back part runs one command at a time: a start
// or stop is applied as it is popped; a tick loads now_ns, then steps one channel per
// cycle through a single deadline compare and period adder while the output register is
// free, then releases the final firing. out_stall holds the output register and the scan.
// Deadline and period storage has no reset; only armed flags and control state are cleared.
module multi_channel_interval_timer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  mcit_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output mcit_pkg::out_t out_data
);

  logic                cmd_vld;
  mcit_pkg::cmd_t      cmd;
  logic                cmd_pop;
  logic                res_free;
  mcit_pkg::res_ctl_t  res;

  logic                out_vld_r, out_vld_nxt;
  mcit_pkg::out_t      out_data_r;

  // Accept and classify beats, queue the commands.
  mcit_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cmd_vld  (cmd_vld),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  // Execute commands against the channel table.
  mcit_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_vld  (cmd_vld),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .res_free (res_free),
    .res      (res)
  );

  // Output register: free when empty or being drained this cycle.
  assign res_free = !out_vld_r || !out_stall;

  always_comb begin
    if (res.push) begin
      out_vld_nxt = 1'b1;
    end else if (out_stall) begin
      out_vld_nxt = out_vld_r;
    end else begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  // Load only on a push; a stalled beat holds.
  always_ff @(posedge clk) begin
    if (res.push) begin
      out_data_r <= res.beat;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// File: tb/multi_channel_interval_timer_check.sv
module multi_channel_interval_timer_check (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  mcit_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  mcit_pkg::out_t out_data,
  output int             fail_count,
  output int             pending
);

  // Shadow copy of the channel table
  logic        chan_armed  [mcit_pkg::NUM_CHANNELS];
  logic [63:0] chan_due_ns [mcit_pkg::NUM_CHANNELS];
  logic [39:0] chan_period [mcit_pkg::NUM_CHANNELS];
  logic        chan_repeat [mcit_pkg::NUM_CHANNELS];

  mcit_pkg::out_t firings_due [$];
  int             errors = 0;

  task automatic apply_command(input mcit_pkg::in_t b);
    mcit_pkg::out_t hits [mcit_pkg::NUM_CHANNELS];
    mcit_pkg::out_t f;
    int             n;
    n = 0;
    if (b.operation == mcit_pkg::OP_START) begin
      if (int'(b.channel) < mcit_pkg::NUM_CHANNELS) begin
        chan_armed[b.channel]  = 1'b1;
        chan_period[b.channel] = b.interval_ns;
        chan_repeat[b.channel] = b.repeat_req;
        chan_due_ns[b.channel] = {1'b0, b.now_ns} + {24'b0, b.interval_ns};
      end
    end else if (b.operation == mcit_pkg::OP_STOP) begin
      if (int'(b.channel) < mcit_pkg::NUM_CHANNELS)
        chan_armed[b.channel] = 1'b0;
    end else if (b.operation == mcit_pkg::OP_TICK) begin
      for (int i = 0; i < mcit_pkg::NUM_CHANNELS; i++) begin
        if (chan_armed[i] && chan_due_ns[i] <= {1'b0, b.now_ns}) begin
          f.fired_channel = 3'(i);
          f.last          = 1'b0;
          hits[n]         = f;
          n++;
          if (chan_repeat[i])
            chan_due_ns[i] = chan_due_ns[i] + {24'b0, chan_period[i]};
          else
            chan_armed[i] = 1'b0;
        end
      end
      for (int j = 0; j < n; j++) begin
        f      = hits[j];
        f.last = (j == n - 1);
        firings_due.push_back(f);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    mcit_pkg::out_t want;
    if (!rst_n) begin
      for (int i = 0; i < mcit_pkg::NUM_CHANNELS; i++) begin
        chan_armed[i]  = 1'b0;
        chan_due_ns[i] = '0;
        chan_period[i] = '0;
        chan_repeat[i] = 1'b0;
      end
      firings_due.delete();
    end else begin
      // results first: anything leaving now belongs to an older tick
      if (out_valid && !out_stall) begin
        if (firings_due.size() == 0) begin
          $display("%0t: unexpected firing, expected none, actual channel %0d last %0b",
                   $time, out_data.fired_channel, out_data.last);
          errors++;
        end else begin
          want = firings_due.pop_front();
          if (out_data.fired_channel !== want.fired_channel) begin
            $display("%0t: fired_channel mismatch, expected %0d, actual %0d",
                     $time, want.fired_channel, out_data.fired_channel);
            errors++;
          end
          if (out_data.last !== want.last) begin
            $display("%0t: last mismatch, expected %0b, actual %0b",
                     $time, want.last, out_data.last);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall)
        apply_command(in_data);
    end
    fail_count <= errors;
    pending    <= firings_due.size();
  end

endmodule

// File: tb/multi_channel_interval_timer_test.sv
module multi_channel_interval_timer_test;

  localparam logic [1:0]  OP_NOISE  = 2'd3;        // undefined opcode, block drops it
  localparam logic [62:0] NOW_MAX   = '1;
  localparam logic [39:0] IVL_MAX   = '1;
  localparam int          RAND_BEATS = 270;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  mcit_pkg::in_t  in_data   = '0;
  logic           out_stall = 1'b0;
  logic           calm      = 1'b0;   // high: neither side idles

  logic           out_valid;
  logic           in_stall;
  mcit_pkg::out_t out_data;
  int             fail_count;
  int             pending;

  always #6 clk = ~clk;

  multi_channel_interval_timer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  multi_channel_interval_timer_check check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver side: stall on about 22 percent of cycles unless calm.
  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 22);
  end

  function automatic logic [62:0] rand_now();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[62:0];
  endfunction

  function automatic logic [39:0] rand_ivl();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[39:0];
  endfunction

  function automatic mcit_pkg::in_t make_beat(input logic [1:0] op, input logic [2:0] ch,
                                              input logic [39:0] ivl, input logic rep,
                                              input logic [62:0] now);
    mcit_pkg::in_t b;
    b.operation   = op;
    b.channel     = ch;
    b.interval_ns = ivl;
    b.repeat_req  = rep;
    b.now_ns      = now;
    return b;
  endfunction

  // Drive one beat and hold it until accepted. Valid stays high on return,
  // so a back-to-back beat never lowers and raises it in the same step.
  task automatic push_beat(input mcit_pkg::in_t b);
    // idle the sender at random before the beat
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold the sender off until every predicted firing has come out.
  task automatic drain_firings();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Safety net: end the run if the block hangs.
  initial begin
    #5000000;
    $display("multi_channel_interval_timer_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    logic [62:0] clock_ns;
    logic [39:0] ivl;
    int          beats;
    int          pick;

    clock_ns = '0;
    beats    = 0;

    // Hold reset, then release it once.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    // Tick with the table empty: nothing due.
    push_beat(make_beat(mcit_pkg::OP_TICK, 3'd0, IVL_MAX, 1'b1, '0));
    // Stop of a channel that was never armed.
    push_beat(make_beat(mcit_pkg::OP_STOP, 3'd3, IVL_MAX, 1'b1, NOW_MAX));
    // Zero-interval periodic channel, due at once on every tick.
    push_beat(make_beat(mcit_pkg::OP_START, 3'd0, '0, 1'b1, '0));
    // Longest one-shot interval.
    push_beat(make_beat(mcit_pkg::OP_START, 3'd7, IVL_MAX, 1'b0, '0));
    push_beat(make_beat(mcit_pkg::OP_START, 3'd1, 40'd5, 1'b0, '0));
    push_beat(make_beat(mcit_pkg::OP_TICK, 3'd7, '0, 1'b0, '0));
    push_beat(make_beat(mcit_pkg::OP_TICK, 3'd0, '0, 1'b0, 63'd5));
    push_beat(make_beat(mcit_pkg::OP_TICK, 3'd0, '0, 1'b0, 63'd5));
    // Restart of an armed channel: rearm from the new time.
    push_beat(make_beat(mcit_pkg::OP_START, 3'd0, 40'd3, 1'b1, 63'd5));
    push_beat(make_beat(mcit_pkg::OP_STOP, 3'd0, '0, 1'b0, '0));
    // One-shot at the far deadline fires here.
    push_beat(make_beat(mcit_pkg::OP_TICK, 3'd0, '0, 1'b0, {23'b0, IVL_MAX}));
    // Undefined opcode with every field set: drop it.
    push_beat(make_beat(OP_NOISE, 3'd7, IVL_MAX, 1'b1, NOW_MAX));
    // Latest start time: one due at once, one beyond the widest deadline a tick can reach.
    push_beat(make_beat(mcit_pkg::OP_START, 3'd2, '0, 1'b0, NOW_MAX));
    push_beat(make_beat(mcit_pkg::OP_START, 3'd3, IVL_MAX, 1'b1, NOW_MAX));
    push_beat(make_beat(mcit_pkg::OP_TICK, 3'd5, IVL_MAX, 1'b1, NOW_MAX));
    // Arm every channel due at once, then one tick fires all of them.
    for (int c = 0; c < mcit_pkg::NUM_CHANNELS; c++)
      push_beat(make_beat(mcit_pkg::OP_START, 3'(c), '0, 1'(c & 1), 63'd100));
    push_beat(make_beat(mcit_pkg::OP_TICK, 3'd0, '0, 1'b0, 63'd100));

    // Pause the sender until the table has flushed its firings.
    drain_firings();
    clock_ns = 63'd200;

    // Random part: mostly a coherent timeline with small intervals, so
    // channels fire often; some jumps in time, long intervals and noise.
    while (beats < RAND_BEATS) begin
      calm <= (beats >= 60 && beats < 140);
      if (beats == 160 || beats == 250)
        drain_firings();
      pick = $urandom_range(99);
      if (pick < 45) begin
        if ($urandom_range(19) == 0)
          clock_ns = rand_now();
        else
          clock_ns = clock_ns + 63'($urandom_range(40));
        push_beat(make_beat(mcit_pkg::OP_TICK, 3'($urandom_range(7)), rand_ivl(),
                            1'($urandom_range(1)), clock_ns));
        beats++;
      end else if (pick < 80) begin
        case ($urandom_range(9))
          0:       ivl = '0;
          1, 2:    ivl = rand_ivl();
          default: ivl = 40'($urandom_range(60));
        endcase
        push_beat(make_beat(mcit_pkg::OP_START, 3'($urandom_range(7)), ivl,
                            1'($urandom_range(1)), clock_ns));
        beats++;
      end else if (pick < 92) begin
        push_beat(make_beat(mcit_pkg::OP_STOP, 3'($urandom_range(7)), rand_ivl(),
                            1'($urandom_range(1)), rand_now()));
        beats++;
      end else begin
        // noise beat; the block drops it, so do not count it
        push_beat(make_beat(OP_NOISE, 3'($urandom_range(7)), rand_ivl(),
                            1'($urandom_range(1)), rand_now()));
      end
    end

    // Drop valid, stop stalling and wait out the tail.
    calm <= 1'b1;
    drain_firings();
    repeat (60) @(posedge clk);

    if (fail_count == 0)
      $display("multi_channel_interval_timer_test OK");
    else
      $display("multi_channel_interval_timer_test NOT OK");
    $finish;
  end

endmodule
